// ===== rtl/core/rpc_frame_header_deframer_macros.svh =====
// Assertion macros for the frame header deframer RTL.
`ifndef RPC_FRAME_HEADER_DEFRAMER_MACROS_SVH
`define RPC_FRAME_HEADER_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checks a property on the rising clock edge, quiet while reset is low.
`define RFHD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition never holds on a rising clock edge.
`define RFHD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define RFHD_ASSERT(lbl, prop, msg)
`define RFHD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/rfhd_pkg.sv =====
// Types and constants shared by the frame header deframer.
`timescale 1ns / 1ps
`default_nettype none

package rfhd_pkg;

  localparam int unsigned HDR_BYTES  = 24;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned HDR_KEEP_W = (HDR_BYTES - 1) * 8;
  localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HDR_BYTES - 1);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_LEN = 2'd2;

  localparam logic [31:0] MAGIC_RST   = 32'h0000_0000;
  localparam logic [7:0]  VERSION_RST = 8'd1;
  localparam logic [31:0] MAX_LEN_RST = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_MAGIC   = 2'd0,
    ERR_VERSION = 2'd1,
    ERR_LENGTH  = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_HALT   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [31:0] magic_value;
    logic [7:0]  expected_version;
    logic [31:0] max_body_len;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    err_e        error_code;
    logic [7:0]  version;
    logic [7:0]  msg_type;
    logic [15:0] flags;
    logic [63:0] seq;
    logic [31:0] body_len;
    logic [31:0] reserved_word;
    logic [7:0]  body_byte;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/rfhd_if.sv =====
// Valid/ready channel interfaces for received bytes and deframer results.
`timescale 1ns / 1ps
`default_nettype none

interface rfhd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rfhd_result_if;
  logic                valid;
  logic                ready;
  rfhd_pkg::kind_e     kind;
  rfhd_pkg::err_e      error_code;
  logic [7:0]          version;
  logic [7:0]          msg_type;
  logic [15:0]         flags;
  logic [63:0]         seq;
  logic [31:0]         body_len;
  logic [31:0]         reserved_word;
  logic [7:0]          body_byte;
  logic                last;

  modport source (
    output valid, output kind, output error_code, output version, output msg_type,
    output flags, output seq, output body_len, output reserved_word,
    output body_byte, output last, input ready
  );
  modport sink (
    input valid, input kind, input error_code, input version, input msg_type,
    input flags, input seq, input body_len, input reserved_word,
    input body_byte, input last, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/rfhd_cfg_regs.sv =====
// Configuration registers of the frame header deframer.
`timescale 1ns / 1ps
`default_nettype none

module rfhd_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rfhd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rfhd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output rfhd_pkg::cfg_t                      cfg_o
);

  rfhd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rfhd_pkg::CFG_IDX_MAGIC:   cfg_d.magic_value      = cfg_wdata_i;
        rfhd_pkg::CFG_IDX_VERSION: cfg_d.expected_version = cfg_wdata_i[7:0];
        rfhd_pkg::CFG_IDX_MAX_LEN: cfg_d.max_body_len     = cfg_wdata_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_value      <= rfhd_pkg::MAGIC_RST;
      cfg_q.expected_version <= rfhd_pkg::VERSION_RST;
      cfg_q.max_body_len     <= rfhd_pkg::MAX_LEN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/rfhd_parser.sv =====
// Header collection, header checks and body pass-through state machine.
`timescale 1ns / 1ps
`default_nettype none

module rfhd_parser (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  rfhd_byte_if.sink     rx_i,
  input  rfhd_pkg::cfg_t cfg_i,
  input  wire logic     push_ready_i,
  output logic          push_valid_o,
  output rfhd_pkg::res_t push_res_o
);

  rfhd_pkg::phase_e                 phase_q, phase_d;
  logic [rfhd_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [31:0]                      rem_q, rem_d;
  logic [rfhd_pkg::HDR_KEEP_W-1:0]  hdr_q, hdr_d;

  logic        accept;
  logic [7:0]  rx_byte;
  logic        hdr_done;
  logic [31:0] hdr_magic;
  logic [7:0]  hdr_version;
  logic [31:0] hdr_len;
  logic        magic_bad;
  logic        version_bad;
  logic        len_bad;
  logic        rem_last;

  assign rx_i.ready  = push_ready_i;
  assign accept      = rx_i.valid && push_ready_i;
  assign rx_byte     = rx_i.data_byte;
  assign hdr_done    = (phase_q == rfhd_pkg::PH_HEADER) && (cnt_q == rfhd_pkg::HDR_LAST);

  // The shift register holds the first 23 header bytes, byte 0 at the top.
  assign hdr_magic   = hdr_q[183:152];
  assign hdr_version = hdr_q[151:144];
  assign hdr_len     = hdr_q[55:24];
  assign magic_bad   = hdr_magic != cfg_i.magic_value;
  assign version_bad = hdr_version != cfg_i.expected_version;
  assign len_bad     = hdr_len > cfg_i.max_body_len;
  assign rem_last    = rem_q <= 32'd1;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    hdr_d   = hdr_q;
    if (accept) begin
      unique case (phase_q)
        rfhd_pkg::PH_HEADER: begin
          hdr_d = {hdr_q[rfhd_pkg::HDR_KEEP_W-9:0], rx_byte};
          if (hdr_done) begin
            cnt_d = '0;
            if (magic_bad || version_bad || len_bad) begin
              phase_d = rfhd_pkg::PH_HALT;
            end else if (hdr_len == 32'd0) begin
              phase_d = rfhd_pkg::PH_HEADER;
            end else begin
              rem_d   = hdr_len;
              phase_d = rfhd_pkg::PH_BODY;
            end
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        rfhd_pkg::PH_BODY: begin
          if (rem_last) begin
            rem_d   = '0;
            cnt_d   = '0;
            phase_d = rfhd_pkg::PH_HEADER;
          end else begin
            rem_d = rem_q - 32'd1;
          end
        end
        rfhd_pkg::PH_HALT: begin
          phase_d = rfhd_pkg::PH_HALT;
        end
        default: begin
          phase_d = rfhd_pkg::PH_HALT;
        end
      endcase
    end
  end

  always_comb begin
    push_valid_o = 1'b0;
    push_res_o   = '0;
    if (accept) begin
      unique case (phase_q)
        rfhd_pkg::PH_HEADER: begin
          if (hdr_done) begin
            push_valid_o = 1'b1;
            priority if (magic_bad) begin
              push_res_o.kind       = rfhd_pkg::KIND_ERROR;
              push_res_o.error_code = rfhd_pkg::ERR_MAGIC;
              push_res_o.last       = 1'b1;
            end else if (version_bad) begin
              push_res_o.kind       = rfhd_pkg::KIND_ERROR;
              push_res_o.error_code = rfhd_pkg::ERR_VERSION;
              push_res_o.last       = 1'b1;
            end else if (len_bad) begin
              push_res_o.kind       = rfhd_pkg::KIND_ERROR;
              push_res_o.error_code = rfhd_pkg::ERR_LENGTH;
              push_res_o.last       = 1'b1;
            end else begin
              push_res_o.kind          = rfhd_pkg::KIND_HEADER;
              push_res_o.version       = hdr_version;
              push_res_o.msg_type      = hdr_q[143:136];
              push_res_o.flags         = hdr_q[135:120];
              push_res_o.seq           = hdr_q[119:56];
              push_res_o.body_len      = hdr_len;
              push_res_o.reserved_word = {hdr_q[23:0], rx_byte};
              push_res_o.last          = hdr_len == 32'd0;
            end
          end
        end
        rfhd_pkg::PH_BODY: begin
          push_valid_o         = 1'b1;
          push_res_o.kind      = rfhd_pkg::KIND_BODY;
          push_res_o.body_byte = rx_byte;
          push_res_o.last      = rem_last;
        end
        default: begin
          push_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rfhd_pkg::PH_HEADER;
      cnt_q   <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/rfhd_out_stage.sv =====
// Result register with a skid entry so requests keep flowing under backpressure.
`timescale 1ns / 1ps
`default_nettype none

`include "rpc_frame_header_deframer_macros.svh"

module rfhd_out_stage (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  input  rfhd_pkg::res_t push_res_i,
  output logic           push_ready_o,
  rfhd_result_if.source  res_o
);

  logic           main_valid_q, main_valid_d;
  logic           skid_valid_q, skid_valid_d;
  rfhd_pkg::res_t main_q, main_d;
  rfhd_pkg::res_t skid_q, skid_d;
  logic           pop;

  assign push_ready_o = !skid_valid_q;
  assign pop          = main_valid_q && res_o.ready;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || pop) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = push_valid_i;
        skid_d       = push_res_i;
      end else begin
        main_valid_d = push_valid_i;
        main_d       = push_res_i;
      end
    end else if (push_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign res_o.valid         = main_valid_q;
  assign res_o.kind          = main_q.kind;
  assign res_o.error_code    = main_q.error_code;
  assign res_o.version       = main_q.version;
  assign res_o.msg_type      = main_q.msg_type;
  assign res_o.flags         = main_q.flags;
  assign res_o.seq           = main_q.seq;
  assign res_o.body_len      = main_q.body_len;
  assign res_o.reserved_word = main_q.reserved_word;
  assign res_o.body_byte     = main_q.body_byte;
  assign res_o.last          = main_q.last;

  `RFHD_ASSERT(a_skid_behind_main, skid_valid_q |-> main_valid_q, "skid entry without main entry")
  `RFHD_ASSERT_NEVER(a_no_push_when_full, push_valid_i && skid_valid_q, "request pushed into full stage")
  `RFHD_ASSERT(a_skid_fills_on_stall, $rose(skid_valid_q) |-> $past(main_valid_q && !res_o.ready), "skid filled without stall")

endmodule

`default_nettype wire

// ===== rtl/core/rpc_frame_header_deframer.sv =====
// Top level of the length-prefixed frame header deframer.
//
//   Channel   Dir  Handshake          Payload
//   rx_i      in   valid/ready        data_byte (8)
//   res_o     out  valid/ready        kind, error_code, header fields, body_byte, last
//   cfg       in   cfg_we_i           cfg_idx_i (2), cfg_wdata_i (32)
//
// One received byte is taken per cycle while rx_i.ready is high; each result is registered in
// the output stage, in its main register or, while the output is stalled, in the skid register.
// The parser state machine handles one byte per cycle whenever the output stage can take it.
// Reset clears the configuration to its defaults and restarts header collection.
// A stalled output fills a one-entry skid register, after which rx_i.ready drops.
// After a header check fails, bytes are still accepted but produce nothing until reset.
`timescale 1ns / 1ps
`default_nettype none

module rpc_frame_header_deframer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  rfhd_byte_if.sink                            rx_i,
  rfhd_result_if.source                        res_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rfhd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rfhd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  rfhd_pkg::cfg_t cfg;
  rfhd_pkg::res_t push_res;
  logic           push_valid;
  logic           push_ready;

  rfhd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rfhd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .cfg_i        (cfg),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_res_o   (push_res)
  );

  rfhd_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_res_i   (push_res),
    .push_ready_o (push_ready),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_rpc_frame_header_deframer.sv =====
// Self-checking testbench for the frame header deframer with directed and random streams.
`timescale 1ns / 1ps

module tb_rpc_frame_header_deframer;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RANDOM_BYTES = 100;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam int unsigned OFS_VERSION = 4;
  localparam int unsigned OFS_TYPE    = 5;
  localparam int unsigned OFS_FLAGS   = 6;
  localparam int unsigned OFS_SEQ     = 8;
  localparam int unsigned OFS_LEN     = 16;
  localparam int unsigned OFS_RSV     = 20;

  localparam logic [rfhd_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  class deframer_scoreboard;
    logic [31:0]      magic_cfg;
    logic [7:0]       version_cfg;
    logic [31:0]      max_len_cfg;
    rfhd_pkg::phase_e phase;
    int unsigned      hdr_idx;
    logic [31:0]      magic_acc;
    logic [7:0]       ver_acc;
    logic [7:0]       type_acc;
    logic [15:0]      flags_acc;
    logic [63:0]      seq_acc;
    logic [31:0]      len_acc;
    logic [31:0]      rsv_acc;
    logic [31:0]      body_left;
    rfhd_pkg::res_t   pending_results[$];
    int unsigned      failures;
    int unsigned      body_results;

    function new();
      magic_cfg    = rfhd_pkg::MAGIC_RST;
      version_cfg  = rfhd_pkg::VERSION_RST;
      max_len_cfg  = rfhd_pkg::MAX_LEN_RST;
      phase        = rfhd_pkg::PH_HEADER;
      hdr_idx      = 0;
      magic_acc    = '0;
      ver_acc      = '0;
      type_acc     = '0;
      flags_acc    = '0;
      seq_acc      = '0;
      len_acc      = '0;
      rsv_acc      = '0;
      body_left    = '0;
      failures     = 0;
      body_results = 0;
    endfunction

    function void set_reg(logic [rfhd_pkg::CFG_IDX_W-1:0] idx,
                          logic [rfhd_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        rfhd_pkg::CFG_IDX_MAGIC: magic_cfg = val;
        rfhd_pkg::CFG_IDX_VERSION: version_cfg = val[7:0];
        rfhd_pkg::CFG_IDX_MAX_LEN: max_len_cfg = val;
        default: ;
      endcase
    endfunction

    function void deframe_byte(logic [7:0] b);
      rfhd_pkg::res_t r;
      r = '0;
      case (phase)
        rfhd_pkg::PH_BODY: begin
          r.kind      = rfhd_pkg::KIND_BODY;
          r.body_byte = b;
          r.last      = (body_left <= 32'd1);
          if (body_left <= 32'd1) begin
            body_left = '0;
            phase     = rfhd_pkg::PH_HEADER;
            hdr_idx   = 0;
          end else begin
            body_left = body_left - 32'd1;
          end
          pending_results.push_back(r);
        end
        rfhd_pkg::PH_HEADER: begin
          if (hdr_idx < OFS_VERSION) magic_acc = {magic_acc[23:0], b};
          else if (hdr_idx == OFS_VERSION) ver_acc = b;
          else if (hdr_idx == OFS_TYPE) type_acc = b;
          else if (hdr_idx < OFS_SEQ) flags_acc = {flags_acc[7:0], b};
          else if (hdr_idx < OFS_LEN) seq_acc = {seq_acc[55:0], b};
          else if (hdr_idx < OFS_RSV) len_acc = {len_acc[23:0], b};
          else rsv_acc = {rsv_acc[23:0], b};
          hdr_idx++;
          if (hdr_idx == rfhd_pkg::HDR_BYTES) begin
            hdr_idx = 0;
            r.last  = 1'b1;
            if (magic_acc != magic_cfg) begin
              r.kind       = rfhd_pkg::KIND_ERROR;
              r.error_code = rfhd_pkg::ERR_MAGIC;
              phase        = rfhd_pkg::PH_HALT;
            end else if (ver_acc != version_cfg) begin
              r.kind       = rfhd_pkg::KIND_ERROR;
              r.error_code = rfhd_pkg::ERR_VERSION;
              phase        = rfhd_pkg::PH_HALT;
            end else if (len_acc > max_len_cfg) begin
              r.kind       = rfhd_pkg::KIND_ERROR;
              r.error_code = rfhd_pkg::ERR_LENGTH;
              phase        = rfhd_pkg::PH_HALT;
            end else begin
              r.kind          = rfhd_pkg::KIND_HEADER;
              r.version       = ver_acc;
              r.msg_type      = type_acc;
              r.flags         = flags_acc;
              r.seq           = seq_acc;
              r.body_len      = len_acc;
              r.reserved_word = rsv_acc;
              r.last          = (len_acc == '0);
              if (len_acc != '0) begin
                body_left = len_acc;
                phase     = rfhd_pkg::PH_BODY;
              end
            end
            pending_results.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(rfhd_pkg::res_t got);
      rfhd_pkg::res_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: result of kind %0d arrived with nothing expected", $time, got.kind);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind == rfhd_pkg::KIND_BODY) body_results++;
      compare_field("kind", want.kind, got.kind);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("version", want.version, got.version);
      compare_field("msg_type", want.msg_type, got.msg_type);
      compare_field("flags", want.flags, got.flags);
      compare_field("seq", want.seq, got.seq);
      compare_field("body_len", want.body_len, got.body_len);
      compare_field("reserved_word", want.reserved_word, got.reserved_word);
      compare_field("body_byte", want.body_byte, got.body_byte);
      compare_field("last", want.last, got.last);
    endfunction

    function void check_drained();
      if (pending_results.size() != 0) begin
        failures++;
        $display("%0d expected results never arrived", pending_results.size());
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                            cfg_we_i;
  logic [rfhd_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [rfhd_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  rfhd_byte_if   rx_if ();
  rfhd_result_if res_if ();

  rpc_frame_header_deframer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  deframer_scoreboard sb = new();

  logic [7:0]  stream[$];
  logic [31:0] cur_magic;
  logic [7:0]  cur_version;
  logic [31:0] cur_limit;
  bit          src_fast;
  int unsigned stall_cycles = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // A result and a request can meet at one edge; the result belongs to an older request.
  always @(posedge clk_i) begin
    rfhd_pkg::res_t got;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got.kind          = res_if.kind;
        got.error_code    = res_if.error_code;
        got.version       = res_if.version;
        got.msg_type      = res_if.msg_type;
        got.flags         = res_if.flags;
        got.seq           = res_if.seq;
        got.body_len      = res_if.body_len;
        got.reserved_word = res_if.reserved_word;
        got.body_byte     = res_if.body_byte;
        got.last          = res_if.last;
        sb.check_result(got);
      end
      if (rx_if.valid && rx_if.ready) sb.deframe_byte(rx_if.data_byte);
    end
  end

  always @(posedge clk_i) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int  gap;
    bit  fast;
    bit  held;
    fast = 1'b0;
    held = 1'b0;
    res_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) fast = !fast;
      gap = fast ? 0 : $urandom_range(0, 10);
      if (!held && sb.body_results >= 3) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  task automatic program_cfg(input logic [31:0] magic, input logic [7:0] ver,
                             input logic [31:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= rfhd_pkg::CFG_IDX_MAGIC;
    cfg_wdata_i <= magic;
    sb.set_reg(rfhd_pkg::CFG_IDX_MAGIC, magic);
    @(posedge clk_i);
    cfg_idx_i   <= rfhd_pkg::CFG_IDX_VERSION;
    cfg_wdata_i <= {24'($urandom), ver};
    sb.set_reg(rfhd_pkg::CFG_IDX_VERSION, {24'h0, ver});
    @(posedge clk_i);
    cfg_idx_i   <= rfhd_pkg::CFG_IDX_MAX_LEN;
    cfg_wdata_i <= limit;
    sb.set_reg(rfhd_pkg::CFG_IDX_MAX_LEN, limit);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_IDX_SPARE;
    cfg_wdata_i <= $urandom;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_magic   = magic;
    cur_version = ver;
    cur_limit   = limit;
    @(posedge clk_i);
  endtask

  task automatic add_header(input logic [31:0] magic, input logic [7:0] ver,
                            input logic [7:0] typ, input logic [15:0] flags,
                            input logic [63:0] seq, input logic [31:0] len,
                            input logic [31:0] rsv);
    logic [rfhd_pkg::HDR_BYTES*8-1:0] hdr;
    hdr = {magic, ver, typ, flags, seq, len, rsv};
    for (int i = rfhd_pkg::HDR_BYTES - 1; i >= 0; i--) stream.push_back(hdr[i*8 +: 8]);
  endtask

  task automatic add_frame(input logic [31:0] magic, input logic [7:0] ver,
                           input logic [7:0] typ, input logic [15:0] flags,
                           input logic [63:0] seq, input logic [31:0] len,
                           input logic [31:0] rsv);
    add_header(magic, ver, typ, flags, seq, len, rsv);
    for (int unsigned i = 0; i < len; i++) stream.push_back(8'($urandom));
  endtask

  task automatic add_random_frame();
    logic [31:0] cap;
    logic [31:0] len;
    cap = (cur_limit < 32'd40) ? cur_limit : 32'd40;
    if ($urandom_range(0, 7) == 0) len = $urandom_range(0, cap);
    else len = $urandom_range(0, (cap < 32'd6) ? cap : 32'd6);
    add_frame(cur_magic, cur_version, 8'($urandom), 16'($urandom), {$urandom, $urandom},
              len, $urandom);
  endtask

  // The valid line is only lowered when a gap follows, so back-to-back bytes keep it high.
  task automatic send_stream();
    int gap;
    while (stream.size() != 0) begin
      if ($urandom_range(0, 39) == 0) src_fast = !src_fast;
      gap = src_fast ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rx_if.valid     <= 1'b1;
      rx_if.data_byte <= stream.pop_front();
      do @(posedge clk_i); while (!rx_if.ready);
    end
    rx_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (sb.pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned    random_bytes;
    int unsigned    frames;
    logic [31:0]    len;
    rfhd_pkg::err_e err_pick;

    rst_ni          = 1'b0;
    rx_if.valid     = 1'b0;
    rx_if.data_byte = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = rfhd_pkg::CFG_IDX_MAGIC;
    cfg_wdata_i     = '0;
    src_fast        = 1'b0;
    random_bytes    = 0;
    cur_magic       = rfhd_pkg::MAGIC_RST;
    cur_version     = rfhd_pkg::VERSION_RST;
    cur_limit       = rfhd_pkg::MAX_LEN_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: empty body, one-byte body with all-ones fields, then a long body
    // that the receiver stalls on.
    add_frame(32'h0, 8'd1, 8'h00, 16'h0000, 64'h0, 32'd0, 32'h0);
    add_frame(32'h0, 8'd1, 8'hFF, 16'hFFFF, '1, 32'd1, 32'hFFFF_FFFF);
    add_frame(32'h0, 8'd1, 8'($urandom), 16'($urandom), {$urandom, $urandom}, 32'd48,
              $urandom);
    send_stream();
    wait_drained();

    program_cfg(32'hFFFF_FFFF, 8'hFF, 32'h0);
    add_frame(32'hFFFF_FFFF, 8'hFF, 8'h00, 16'h0000, 64'h0, 32'd0, 32'h0);
    add_frame(32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, '1, 32'd0, 32'hFFFF_FFFF);
    send_stream();
    wait_drained();

    // A body exactly at the length limit must pass.
    program_cfg($urandom, 8'h00, $urandom_range(1, 8));
    add_frame(cur_magic, cur_version, 8'h5A, 16'hA55A, {$urandom, $urandom}, cur_limit,
              $urandom);
    add_frame(cur_magic, cur_version, 8'h01, 16'h8001, {$urandom, $urandom}, cur_limit - 1,
              $urandom);
    send_stream();
    wait_drained();

    while (random_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 3))
        0: cur_magic = 32'h0;
        1: cur_magic = 32'hFFFF_FFFF;
        default: cur_magic = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: len = 32'hFFFF_FFFF;
        1: len = 32'h0;
        2: len = $urandom_range(0, 12);
        default: len = $urandom_range(0, 40);
      endcase
      program_cfg(cur_magic, 8'($urandom), len);
      frames = $urandom_range(2, 5);
      repeat (frames) add_random_frame();
      random_bytes += stream.size();
      send_stream();
      wait_drained();
    end

    // One failing header per run, since the block stays halted until reset.
    program_cfg($urandom, 8'($urandom), $urandom_range(0, 200));
    err_pick = rfhd_pkg::err_e'($urandom_range(0, 2));
    case (err_pick)
      rfhd_pkg::ERR_MAGIC:
        add_header(cur_magic ^ (32'd1 << $urandom_range(0, 31)), 8'($urandom),
                   8'($urandom), 16'($urandom), {$urandom, $urandom}, $urandom, $urandom);
      rfhd_pkg::ERR_VERSION:
        add_header(cur_magic, cur_version ^ (8'd1 << $urandom_range(0, 7)), 8'($urandom),
                   16'($urandom), {$urandom, $urandom}, $urandom, $urandom);
      default:
        add_header(cur_magic, cur_version, 8'($urandom), 16'($urandom),
                   {$urandom, $urandom}, cur_limit + 1 + $urandom_range(0, 1000), $urandom);
    endcase
    add_frame(cur_magic, cur_version, 8'($urandom), 16'($urandom), {$urandom, $urandom},
              32'd0, $urandom);
    repeat ($urandom_range(10, 30)) stream.push_back(8'($urandom));
    send_stream();
    wait_drained();

    sb.check_drained();
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
